[rtl/core/rwte_pkg.sv]
// Shared types, constants and field widths for the register write trace encoder.
package rwte_pkg;

    // Input field widths.
    localparam int REG_INDEX_W  = 7;
    localparam int REG_VALUE_W  = 8;
    localparam int EVENT_TIME_W = 32;
    localparam int IN_DATA_W    = 48;

    // Output field widths.
    localparam int CODE_WORD_W  = 16;
    localparam int OUT_USER_W   = 2;

    // Defaults for the top-level parameters.
    localparam int REG_COUNT_DEF       = 128;
    localparam int MAX_DELAY_WORDS_DEF = 63;

    // One delay word carries at most this many ticks.
    localparam logic [EVENT_TIME_W-1:0] DELAY_CHUNK = 32'h0000_7fff;
    localparam logic [CODE_WORD_W-1:0]  DELAY_FLAG  = 16'h8000;

    // Writes to the envelope shape register are never dropped as repeats.
    localparam logic [3:0] ENV_REG = 4'd13;

    // Result of the shared subtract and compare unit.
    typedef struct packed {
        logic [EVENT_TIME_W-1:0] diff;
        logic                    borrow;
        logic                    zero;
    } alu_res_t;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_LOOKUP = 5'b00010,
        ST_CLAMP  = 5'b00100,
        ST_DELAY  = 5'b01000,
        ST_WORD   = 5'b10000
    } state_t;

endpackage

[rtl/core/rwte_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module rwte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/rwte_alu.sv]
// Shared 32-bit subtract and compare unit used by every arithmetic step.
module rwte_alu (
    input  logic [rwte_pkg::EVENT_TIME_W-1:0] op_a,
    input  logic [rwte_pkg::EVENT_TIME_W-1:0] op_b,
    output rwte_pkg::alu_res_t                res
);

    logic [rwte_pkg::EVENT_TIME_W:0] wide;

    // The extra top bit of the difference is the borrow, set when op_a < op_b.
    assign wide       = {1'b0, op_a} - {1'b0, op_b};
    assign res.diff   = wide[rwte_pkg::EVENT_TIME_W-1:0];
    assign res.borrow = wide[rwte_pkg::EVENT_TIME_W];
    assign res.zero   = (wide[rwte_pkg::EVENT_TIME_W-1:0] == '0);

endmodule

[rtl/core/register_write_trace_encoder_core.sv]
// Top level of the register write trace encoder: sequencer, shadow store and output beat.
//
// The block takes timestamped sound-chip register writes on the s_axis channel and
// turns each kept write into 16-bit command words on the m_axis channel. A write
// that repeats the last value stored for its register is dropped without output,
// except writes to the envelope shape register (index mod 16 equal to 13). A kept
// write first produces the time gap since the previous kept write as delay words
// (bit 15 set, up to 32767 ticks each), then one word of register<<8 | value,
// which carries tlast. tuser flags time running backwards and a clamped gap.
//
// One input beat is handled at a time and s_axis_tready is high only while idle.
// A dropped repeat returns to idle from lookup; a kept write passes lookup, clamp,
// delay and word states, all driven by one shared 32-bit subtractor that forms
// the gap, tests it against the clamp limit, then peels off one chunk per delay word.
// The shadow values live in a RAM with a registered read; a valid bit per
// register in flip-flops marks entries written since reset.
//
// Reset clears the valid bits, the previous time and all control state, so the
// block is ready for input as soon as reset is released. When the receiver holds
// m_axis_tready low, the output beat holds and the sequencer waits for it.
module register_write_trace_encoder_core #(
    parameter int REG_COUNT       = rwte_pkg::REG_COUNT_DEF,
    parameter int MAX_DELAY_WORDS = rwte_pkg::MAX_DELAY_WORDS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input beats: tdata = reg_index[6:0], reg_value[14:7], event_time[46:15], zero[47].
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [rwte_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // Output beats: tdata = code_word[15:0].
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [rwte_pkg::CODE_WORD_W-1:0]   m_axis_tdata,
    // tlast = last_of_run.
    output logic                               m_axis_tlast,
    // tuser = time_backwards[0], delay_clamped[1].
    output logic [rwte_pkg::OUT_USER_W-1:0]    m_axis_tuser
);

    localparam int AW = $clog2(REG_COUNT);
    localparam int TW = rwte_pkg::EVENT_TIME_W;
    localparam logic [rwte_pkg::REG_INDEX_W:0] REG_LIMIT = (rwte_pkg::REG_INDEX_W + 1)'(REG_COUNT);
    localparam logic [TW-1:0] DELAY_LIMIT = TW'(MAX_DELAY_WORDS * 32'h0000_7fff);

    rwte_pkg::state_t state_reg, state_next;

    logic [rwte_pkg::REG_INDEX_W-1:0]  idx_reg, idx_next;
    logic [rwte_pkg::REG_VALUE_W-1:0]  val_reg, val_next;
    logic [TW-1:0]                     time_reg, time_next;
    logic [TW-1:0]                     prev_reg, prev_next;
    logic [TW-1:0]                     gap_reg, gap_next;
    logic                              back_reg, back_next;
    logic                              clamp_reg, clamp_next;
    logic [REG_COUNT-1:0]              valid_reg, valid_next;

    logic                              ov_reg, ov_next;
    logic [rwte_pkg::CODE_WORD_W-1:0]  ow_reg, ow_next;
    logic                              ol_reg, ol_next;
    logic                              ob_reg, ob_next;
    logic                              oc_reg, oc_next;

    logic [TW-1:0]                     op_a, op_b;
    rwte_pkg::alu_res_t                alu_res;

    logic                              ram_we;
    logic [AW-1:0]                     ram_raddr;
    logic [rwte_pkg::REG_VALUE_W-1:0]  ram_rdata;
    logic [AW-1:0]                     idx_addr;
    logic                              in_range;
    logic                              repeat_write;
    logic                              out_free;
    logic                              accept;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign idx_addr = idx_reg[AW-1:0];
    assign in_range = ({1'b0, idx_reg} < REG_LIMIT);
    assign out_free = !ov_reg || m_axis_tready;

    // A repeat is only possible for a stored register other than the envelope shape.
    assign repeat_write = (idx_reg[3:0] != rwte_pkg::ENV_REG) && in_range
                          && valid_reg[idx_addr] && (ram_rdata == val_reg);

    assign ram_raddr = s_axis_tdata[AW-1:0];
    assign ram_we    = (state_reg == rwte_pkg::ST_LOOKUP) && !repeat_write && in_range;

    rwte_ram #(
        .WIDTH (rwte_pkg::REG_VALUE_W),
        .DEPTH (REG_COUNT)
    ) u_shadow (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_addr),
        .wdata (val_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Operand selection for the shared subtractor follows the sequencer state.
    always_comb
    begin
        unique case (state_reg)
            rwte_pkg::ST_LOOKUP:
            begin
                op_a = time_reg;
                op_b = prev_reg;
            end
            rwte_pkg::ST_CLAMP:
            begin
                op_a = gap_reg;
                op_b = DELAY_LIMIT;
            end
            default:
            begin
                op_a = gap_reg;
                op_b = rwte_pkg::DELAY_CHUNK;
            end
        endcase
    end

    rwte_alu u_alu (
        .op_a (op_a),
        .op_b (op_b),
        .res  (alu_res)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        time_next  = time_reg;
        prev_next  = prev_reg;
        gap_next   = gap_reg;
        back_next  = back_reg;
        clamp_next = clamp_reg;
        valid_next = valid_reg;
        ov_next    = ov_reg && !m_axis_tready;
        ow_next    = ow_reg;
        ol_next    = ol_reg;
        ob_next    = ob_reg;
        oc_next    = oc_reg;

        unique case (state_reg)
            rwte_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = s_axis_tdata[6:0];
                    val_next   = s_axis_tdata[14:7];
                    time_next  = s_axis_tdata[46:15];
                    state_next = rwte_pkg::ST_LOOKUP;
                end
            end
            rwte_pkg::ST_LOOKUP:
            begin
                if (repeat_write)
                begin
                    state_next = rwte_pkg::ST_IDLE;
                end
                else
                begin
                    if (in_range)
                    begin
                        valid_next[idx_addr] = 1'b1;
                    end
                    // A borrow means time ran backwards: no delay at all.
                    back_next  = alu_res.borrow;
                    gap_next   = alu_res.borrow ? '0 : alu_res.diff;
                    prev_next  = time_reg;
                    clamp_next = 1'b0;
                    state_next = rwte_pkg::ST_CLAMP;
                end
            end
            rwte_pkg::ST_CLAMP:
            begin
                if (!alu_res.borrow && !alu_res.zero)
                begin
                    clamp_next = 1'b1;
                    gap_next   = DELAY_LIMIT;
                end
                state_next = rwte_pkg::ST_DELAY;
            end
            rwte_pkg::ST_DELAY:
            begin
                if (gap_reg == '0)
                begin
                    state_next = rwte_pkg::ST_WORD;
                end
                else if (out_free)
                begin
                    ov_next  = 1'b1;
                    ol_next  = 1'b0;
                    ob_next  = back_reg;
                    oc_next  = clamp_reg;
                    if (alu_res.borrow)
                    begin
                        ow_next  = rwte_pkg::DELAY_FLAG | gap_reg[rwte_pkg::CODE_WORD_W-1:0];
                        gap_next = '0;
                    end
                    else
                    begin
                        ow_next  = rwte_pkg::DELAY_FLAG
                                   | rwte_pkg::DELAY_CHUNK[rwte_pkg::CODE_WORD_W-1:0];
                        gap_next = alu_res.diff;
                    end
                end
            end
            rwte_pkg::ST_WORD:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ow_next    = {1'b0, idx_reg, val_reg};
                    ol_next    = 1'b1;
                    ob_next    = back_reg;
                    oc_next    = clamp_reg;
                    state_next = rwte_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rwte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rwte_pkg::ST_IDLE;
            prev_reg  <= '0;
            valid_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            prev_reg  <= prev_next;
            valid_reg <= valid_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        time_reg  <= time_next;
        gap_reg   <= gap_next;
        back_reg  <= back_next;
        clamp_reg <= clamp_next;
        ow_reg    <= ow_next;
        ol_reg    <= ol_next;
        ob_reg    <= ob_next;
        oc_reg    <= oc_next;
    end

    assign s_axis_tready = (state_reg == rwte_pkg::ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = ow_reg;
    assign m_axis_tlast  = ol_reg;
    assign m_axis_tuser  = {oc_reg, ob_reg};

endmodule

[tb/register_write_trace_encoder_core_tb.sv]
// Self-checking testbench for the register write trace encoder core.
`timescale 1ns / 100ps

module register_write_trace_encoder_core_tb;

    localparam int          REGS        = rwte_pkg::REG_COUNT_DEF;
    localparam int unsigned MAX_WORDS   = rwte_pkg::MAX_DELAY_WORDS_DEF;
    localparam int unsigned CHUNK_TICKS = rwte_pkg::DELAY_CHUNK;
    localparam int          CALM_ITEMS  = 40;
    localparam int          SETTLE_CYC  = 80;
    localparam int          CYCLE_LIMIT = 1_200_000;

    typedef struct {
        logic [rwte_pkg::REG_INDEX_W-1:0]  reg_idx;
        logic [rwte_pkg::REG_VALUE_W-1:0]  byte_val;
        logic [rwte_pkg::EVENT_TIME_W-1:0] stamp;
        bit                                drain;
    } write_item_t;

    typedef struct packed {
        logic [rwte_pkg::CODE_WORD_W-1:0] code;
        logic                             last;
        logic                             back;
        logic                             clamp;
    } code_beat_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [rwte_pkg::IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [rwte_pkg::CODE_WORD_W-1:0] m_axis_tdata;
    logic                             m_axis_tlast;
    logic [rwte_pkg::OUT_USER_W-1:0]  m_axis_tuser;

    // Writes waiting to go out, and command words still owed by the block.
    write_item_t pending_writes[$];
    code_beat_t  owed_words[$];

    // Shadow copy of the block state, kept by the predictor.
    bit                                shadow_known [REGS];
    logic [rwte_pkg::REG_VALUE_W-1:0]  shadow_byte  [REGS];
    logic [rwte_pkg::EVENT_TIME_W-1:0] last_kept_time;

    // Mirror of the last value sent per register, used to aim repeats.
    bit                                sent_known [REGS];
    logic [rwte_pkg::REG_VALUE_W-1:0]  sent_byte  [REGS];

    int          total_writes;
    int          writes_issued;
    int          writes_accepted;
    int          writes_kept;
    int          writes_dropped;
    int          clamped_runs;
    int          backward_runs;
    int          words_predicted;
    int          words_checked;
    int          mismatches;
    int          cycle_count;
    int          src_wait;
    int          sink_wait;
    bit          src_bursty;
    bit          sink_bursty;
    logic        calm_tail;
    write_item_t on_bus;
    code_beat_t  want;

    register_write_trace_encoder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Works out the command words for one accepted write and queues them.
    function automatic void encode_write(input write_item_t w);
        logic [rwte_pkg::EVENT_TIME_W-1:0] gap;
        logic [rwte_pkg::EVENT_TIME_W-1:0] chunk;
        int unsigned                       n_words;
        logic                              back;
        logic                              clamp;
        code_beat_t                        b;
        back  = 1'b0;
        clamp = 1'b0;
        gap   = '0;
        if (w.reg_idx[3:0] != rwte_pkg::ENV_REG && int'(w.reg_idx) < REGS &&
            shadow_known[w.reg_idx] && shadow_byte[w.reg_idx] == w.byte_val)
        begin
            writes_dropped++;
            return;
        end
        if (int'(w.reg_idx) < REGS)
        begin
            shadow_known[w.reg_idx] = 1'b1;
            shadow_byte[w.reg_idx]  = w.byte_val;
        end
        if (w.stamp < last_kept_time)
            back = 1'b1;
        else
            gap = w.stamp - last_kept_time;
        last_kept_time = w.stamp;
        n_words = gap / CHUNK_TICKS + ((gap % CHUNK_TICKS) != 0 ? 1 : 0);
        if (n_words > MAX_WORDS)
        begin
            n_words = MAX_WORDS;
            clamp   = 1'b1;
            gap     = MAX_WORDS * CHUNK_TICKS;
        end
        for (int unsigned i = 0; i < n_words; i++)
        begin
            chunk = (gap < CHUNK_TICKS) ? gap : CHUNK_TICKS;
            gap   = gap - chunk;
            b = '{code: rwte_pkg::DELAY_FLAG | chunk[rwte_pkg::CODE_WORD_W-1:0],
                  last: 1'b0, back: back, clamp: clamp};
            owed_words.push_back(b);
        end
        b = '{code: {1'b0, w.reg_idx, w.byte_val}, last: 1'b1, back: back, clamp: clamp};
        owed_words.push_back(b);
        words_predicted += n_words + 1;
        writes_kept++;
        if (back)
            backward_runs++;
        if (clamp)
            clamped_runs++;
    endfunction

    task automatic add_write(input int reg_idx, input int byte_val,
                             input logic [rwte_pkg::EVENT_TIME_W-1:0] stamp,
                             input bit drain);
        write_item_t w;
        w.reg_idx  = reg_idx[rwte_pkg::REG_INDEX_W-1:0];
        w.byte_val = byte_val[rwte_pkg::REG_VALUE_W-1:0];
        w.stamp    = stamp;
        w.drain    = drain;
        sent_known[w.reg_idx] = 1'b1;
        sent_byte[w.reg_idx]  = w.byte_val;
        pending_writes.push_back(w);
    endtask

    // Source side: presents pending writes and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            calm_tail     <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                encode_write(on_bus);
                writes_accepted++;
            end
            if (s_axis_tvalid && !s_axis_tready)
            begin
                // Beat is held until the block takes it.
            end
            else if (src_wait > 0)
            begin
                src_wait--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_writes.size() == 0 ||
                     (pending_writes[0].drain && words_predicted != words_checked))
            begin
                s_axis_tvalid <= 1'b0;
            end
            else
            begin
                on_bus = pending_writes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, on_bus.stamp, on_bus.byte_val, on_bus.reg_idx};
                writes_issued++;
                calm_tail <= (writes_issued + CALM_ITEMS >= total_writes);
                if (!calm_tail && src_bursty && $urandom_range(0, 2) == 0)
                    src_wait = $urandom_range(1, 13);
                if ($urandom_range(0, 15) == 0)
                    src_bursty = !src_bursty;
            end
        end
    end

    // Sink side: stalls in bursts and checks every beat against the oldest owed word.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            words_checked <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (owed_words.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: beat with nothing expected: word=%h last=%b user=%b",
                             $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
                end
                else
                begin
                    want = owed_words.pop_front();
                    if (m_axis_tdata !== want.code || m_axis_tlast !== want.last ||
                        m_axis_tuser[0] !== want.back || m_axis_tuser[1] !== want.clamp)
                    begin
                        mismatches++;
                        $display("%0t: expected word=%h last=%b back=%b clamp=%b",
                                 $time, want.code, want.last, want.back, want.clamp);
                        $display("%0t:   actual word=%h last=%b back=%b clamp=%b",
                                 $time, m_axis_tdata, m_axis_tlast,
                                 m_axis_tuser[0], m_axis_tuser[1]);
                    end
                end
                words_checked <= words_checked + 1;
            end
            if (sink_wait > 0)
            begin
                sink_wait--;
                m_axis_tready <= 1'b0;
            end
            else if (!calm_tail && sink_bursty && $urandom_range(0, 9) == 0)
            begin
                sink_wait = $urandom_range(0, 12);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
            if ($urandom_range(0, 63) == 0)
                sink_bursty = !sink_bursty;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d words still owed", $time, owed_words.size());
            $display("register_write_trace_encoder_core test failed");
            $finish;
        end
    end

    initial
    begin
        logic [rwte_pkg::EVENT_TIME_W-1:0] t_now;
        int                                pick;
        int                                reg_idx;
        int                                byte_val;
        int unsigned                       k;

        last_kept_time = '0;
        src_bursty     = 1'b1;
        sink_bursty    = 1'b1;

        // Directed writes: repeats, envelope register, exact chunk edges,
        // clamping, time running backwards and equal time.
        add_write(0, 8'h00, 32'd0, 1'b0);
        add_write(0, 8'h00, 32'd5, 1'b0);
        add_write(13, 8'h0a, 32'd10, 1'b0);
        add_write(13, 8'h0a, 32'd10, 1'b0);
        t_now = 32'd10 + CHUNK_TICKS;
        add_write(127, 8'hff, t_now, 1'b0);
        t_now = t_now + CHUNK_TICKS + 1;
        add_write(29, 8'hff, t_now, 1'b0);
        add_write(29, 8'hff, t_now, 1'b0);
        t_now = t_now + MAX_WORDS * CHUNK_TICKS;
        add_write(1, 8'h80, t_now, 1'b0);
        t_now = t_now + MAX_WORDS * CHUNK_TICKS + 1;
        add_write(2, 8'h55, t_now, 1'b1);
        add_write(3, 8'haa, 32'hffff_ffff, 1'b0);
        add_write(4, 8'h01, 32'd0, 1'b0);
        add_write(4, 8'h01, 32'd100, 1'b0);
        add_write(4, 8'h02, 32'd50, 1'b0);
        add_write(45, 8'h00, 32'd40, 1'b0);
        add_write(127, 8'hff, 32'd40, 1'b0);
        add_write(64, 8'h7f, 32'd41, 1'b0);
        add_write(127, 8'h00, 32'd41, 1'b0);
        add_write(127, 8'hff, 32'd41, 1'b0);
        t_now = 32'd41 + 2 * CHUNK_TICKS - 1;
        add_write(93, 8'h5a, t_now, 1'b0);

        // Random writes, biased toward a few hot registers so repeats happen.
        for (int i = 0; i < 250; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                reg_idx = $urandom_range(0, 15);
            else
                reg_idx = $urandom_range(0, 127);
            if ($urandom_range(0, 99) < 30 && sent_known[reg_idx])
                byte_val = sent_byte[reg_idx];
            else
                byte_val = $urandom_range(0, 255);

            pick = $urandom_range(0, 99);
            if (pick < 25)
                t_now = t_now + $urandom_range(0, 40);
            else if (pick < 45)
                t_now = t_now + $urandom_range(1, 3 * CHUNK_TICKS);
            else if (pick < 55)
            begin
                k = $urandom_range(1, MAX_WORDS);
                t_now = t_now + k * CHUNK_TICKS + $urandom_range(0, 2) - 1;
            end
            else if (pick < 65)
            begin
                // Equal time: no delay words.
            end
            else if (pick < 77)
                t_now = t_now - $urandom_range(1, 1_000_000);
            else if (pick < 82)
                t_now = $urandom();
            else if (pick < 87)
                t_now = t_now + MAX_WORDS * CHUNK_TICKS + $urandom_range(0, 2);
            else
                t_now = t_now + $urandom_range(0, 200_000);
            add_write(reg_idx, byte_val, t_now, (i % 60) == 59);
        end
        total_writes = pending_writes.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (writes_accepted < total_writes || words_checked != words_predicted)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        if (owed_words.size() != 0)
            $display("%0t: %0d expected words never arrived", $time, owed_words.size());
        $display("Sent %0d writes: %0d kept, %0d dropped as repeats, %0d words checked.",
                 writes_accepted, writes_kept, writes_dropped, words_checked);
        $display("Kept writes with clamped gap: %0d, with time running backwards: %0d.",
                 clamped_runs, backward_runs);
        if (mismatches == 0 && owed_words.size() == 0)
            $display("register_write_trace_encoder_core test passed");
        else
            $display("register_write_trace_encoder_core test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/rwte_pkg.sv
rtl/core/rwte_ram.sv
rtl/core/rwte_alu.sv
rtl/core/register_write_trace_encoder_core.sv
tb/register_write_trace_encoder_core_tb.sv
